FILE: rtl/bdt_pkg.sv
// Shared types, constants and the month table for the civil time to epoch converter.
package bdt_pkg;

   localparam int ACC_W = 38;        // accumulator: 37-bit result plus headroom for sign
   localparam int ADD_W = 14;        // addend into the multiply-add unit
   localparam int MUL_W = 7;         // constant multiplier width

   localparam int YEAR_W = 12;
   localparam int EPOCH_W = 37;

   localparam int EPOCH_YEAR = 1970;
   localparam int CENTURY_BASE = 1900;
   localparam int CENTURY_STEP = 100;
   localparam int DAYS_PER_YEAR = 365;
   localparam int LEAP_CYCLE = 400;
   localparam int HOURS_PER_DAY = 24;
   localparam int MINS_PER_HOUR = 60;
   localparam int MAX_SECOND = 61;
   localparam int MAX_MINUTE = 59;
   localparam int MAX_HOUR = 23;
   localparam int MAX_MONTH = 11;
   localparam int FEB_INDEX = 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_YEARS,
      ST_MONTH,
      ST_HOUR,
      ST_MIN,
      ST_SEC,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      MUL_ONE,
      MUL_DAY_HOURS,
      MUL_SIXTY
   } mul_sel_type;

   typedef struct packed {
      logic                     en;      // update accumulator this cycle
      logic                     clr;     // zero accumulator
      mul_sel_type              mul_sel;
      logic signed [ADD_W-1:0]  addend;
   } mac_ctrl_type;

   // days in the year before the first of the given zero-based month (common year)
   function automatic logic [8:0] days_before_month(input logic [3:0] mon);
      logic [8:0] d;
      case (mon)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd31;
         4'd2:    d = 9'd59;
         4'd3:    d = 9'd90;
         4'd4:    d = 9'd120;
         4'd5:    d = 9'd151;
         4'd6:    d = 9'd181;
         4'd7:    d = 9'd212;
         4'd8:    d = 9'd243;
         4'd9:    d = 9'd273;
         4'd10:   d = 9'd304;
         4'd11:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

FILE: rtl/bdt_mac_unit.sv
// Shared multiply-add unit: acc <= acc * k + addend, k from a small constant set.
module bdt_mac_unit
   import bdt_pkg::*;
(
   input  logic                    clock,
   input  mac_ctrl_type            ctrl,
   output logic signed [ACC_W-1:0] acc
);

   logic signed [ACC_W-1:0]       acc_ff;
   logic signed [ACC_W-1:0]       acc_in;
   logic        [MUL_W-1:0]       k_val;
   logic signed [ACC_W+MUL_W:0]   prod;
   logic signed [ACC_W-1:0]       prod_trunc;

   always_comb begin
      case (ctrl.mul_sel)
         MUL_ONE:       k_val = MUL_W'(1);
         MUL_DAY_HOURS: k_val = MUL_W'(HOURS_PER_DAY);
         MUL_SIXTY:     k_val = MUL_W'(MINS_PER_HOUR);
         default:       k_val = MUL_W'(1);
      endcase
   end

   always_comb begin
      prod       = acc_ff * $signed({1'b0, k_val});
      prod_trunc = prod[ACC_W-1:0];
      if (ctrl.clr) begin
         acc_in = '0;
      end else if (ctrl.en) begin
         acc_in = prod_trunc + ACC_W'(ctrl.addend);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

FILE: rtl/broken_down_time_to_epoch_seconds.sv
// Top level: broken-down civil time to Unix epoch seconds, sequenced over a shared multiply-add.
//
// Usage:
//  - Request channel (req_*): one broken-down time per transfer, taken when req_valid is
//    high and req_stall is low. req_stall is high while an item is being converted.
//  - Response channel (rsp_*): one result per request. rsp_epoch_seconds is seconds since
//    1970-01-01 UTC in 37-bit two's complement; rsp_valid_res is 0 with seconds -1 when a
//    field is out of range (second > 61, minute > 59, hour > 23, day 0, month > 11).
//  - Sequencing: an out-of-range item skips the conversion steps and goes straight to
//    its last state. The day count walks one year per cycle through the shared multiply-add
//    unit; the month, hour, minute and second steps then follow in that order.
//  - Throughput: one item at a time; the next request is taken the cycle after the result
//    is loaded into the response register, so a new item can be converted while the
//    previous result still waits on rsp_stall.
//  - rsp_stall: the response register holds its payload; a finished item waits in its
//    last state until the register is free.
//  - Reset (synchronous, active high): returns to idle and drops rsp_valid.
module broken_down_time_to_epoch_seconds
   import bdt_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [5:0]                req_second,
   input  logic [5:0]                req_minute,
   input  logic [4:0]                req_hour,
   input  logic [4:0]                req_day_of_month,
   input  logic [3:0]                req_month_index,
   input  logic [11:0]               req_year_value,
   input  logic signed [11:0]        req_zone_minutes,
   input  logic                      req_dst_active,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [EPOCH_W-1:0] rsp_epoch_seconds,
   output logic                      rsp_valid_res
);

   state_type state_ff, state_in;

   // latched request fields
   logic [5:0]         sec_ff,  min_ff;
   logic [4:0]         hour_ff, mday_ff;
   logic [3:0]         mon_ff;
   logic               dst_ff;
   logic signed [11:0] zone_ff;
   logic [YEAR_W-1:0]  year_tgt_ff;
   logic               bad_ff;

   // year walk: current year and its residues for the Gregorian leap test
   logic [YEAR_W-1:0]  year_cur_ff;
   logic [1:0]         m4_ff;
   logic [6:0]         m100_ff;
   logic [8:0]         m400_ff;
   logic               leap_now;

   logic                      rsp_valid_ff;
   logic signed [EPOCH_W-1:0] rsp_secs_ff;
   logic                      rsp_res_ff;

   logic req_xfer;
   logic req_bad;
   logic [YEAR_W:0] year_a, year_b;
   logic out_free;
   logic out_load;

   mac_ctrl_type            mac_ctrl;
   logic signed [ACC_W-1:0] acc;

   bdt_mac_unit u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .acc   (acc)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign req_bad = (req_second > 6'(MAX_SECOND)) || (req_minute > 6'(MAX_MINUTE)) ||
                    (req_hour > 5'(MAX_HOUR)) || (req_day_of_month == 5'd0) ||
                    (req_month_index > 4'(MAX_MONTH));

   // two-digit and offset years: add 1900, then 100 if still before the epoch
   always_comb begin
      year_a = {1'b0, req_year_value};
      if (year_a < (YEAR_W+1)'(EPOCH_YEAR)) begin
         year_a = year_a + (YEAR_W+1)'(CENTURY_BASE);
      end
      year_b = year_a;
      if (year_b < (YEAR_W+1)'(EPOCH_YEAR)) begin
         year_b = year_b + (YEAR_W+1)'(CENTURY_STEP);
      end
   end

   assign leap_now = (m4_ff == 2'd0) && ((m100_ff != 7'd0) || (m400_ff == 9'd0));

   // sequencer
   always_comb begin
      state_in        = state_ff;
      mac_ctrl.en     = 1'b0;
      mac_ctrl.clr    = 1'b0;
      mac_ctrl.mul_sel = MUL_ONE;
      mac_ctrl.addend = '0;
      out_load        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               mac_ctrl.clr = 1'b1;
               state_in     = req_bad ? ST_DONE : ST_YEARS;
            end
         end
         ST_YEARS: begin
            if (year_cur_ff == year_tgt_ff) begin
               state_in = ST_MONTH;
            end else begin
               mac_ctrl.en     = 1'b1;
               mac_ctrl.addend = ADD_W'(DAYS_PER_YEAR) + ADD_W'(leap_now);
            end
         end
         ST_MONTH: begin
            // residues now belong to the target year
            mac_ctrl.en     = 1'b1;
            mac_ctrl.addend = ADD_W'(days_before_month(mon_ff)) +
                              ADD_W'(leap_now && (mon_ff > 4'(FEB_INDEX))) +
                              ADD_W'(mday_ff) - ADD_W'(1);
            state_in        = ST_HOUR;
         end
         ST_HOUR: begin
            mac_ctrl.en      = 1'b1;
            mac_ctrl.mul_sel = MUL_DAY_HOURS;
            mac_ctrl.addend  = ADD_W'(hour_ff) - ADD_W'(dst_ff);
            state_in         = ST_MIN;
         end
         ST_MIN: begin
            // zone offset folded in at minute granularity
            mac_ctrl.en      = 1'b1;
            mac_ctrl.mul_sel = MUL_SIXTY;
            mac_ctrl.addend  = ADD_W'(min_ff) - ADD_W'(zone_ff);
            state_in         = ST_SEC;
         end
         ST_SEC: begin
            mac_ctrl.en      = 1'b1;
            mac_ctrl.mul_sel = MUL_SIXTY;
            mac_ctrl.addend  = ADD_W'(sec_ff);
            state_in         = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // request latch and year walk
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         sec_ff      <= req_second;
         min_ff      <= req_minute;
         hour_ff     <= req_hour;
         mday_ff     <= req_day_of_month;
         mon_ff      <= req_month_index;
         dst_ff      <= req_dst_active;
         zone_ff     <= req_zone_minutes;
         year_tgt_ff <= year_b[YEAR_W-1:0];
         bad_ff      <= req_bad;
         year_cur_ff <= YEAR_W'(EPOCH_YEAR);
         m4_ff       <= 2'(EPOCH_YEAR % 4);
         m100_ff     <= 7'(EPOCH_YEAR % CENTURY_STEP);
         m400_ff     <= 9'(EPOCH_YEAR % LEAP_CYCLE);
      end else if ((state_ff == ST_YEARS) && (year_cur_ff != year_tgt_ff)) begin
         year_cur_ff <= year_cur_ff + YEAR_W'(1);
         m4_ff       <= m4_ff + 2'd1;
         m100_ff     <= (m100_ff == 7'(CENTURY_STEP - 1)) ? 7'd0 : m100_ff + 7'd1;
         m400_ff     <= (m400_ff == 9'(LEAP_CYCLE - 1)) ? 9'd0 : m400_ff + 9'd1;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         if (bad_ff) begin
            rsp_secs_ff <= '1;
            rsp_res_ff  <= 1'b0;
         end else begin
            rsp_secs_ff <= acc[EPOCH_W-1:0];
            rsp_res_ff  <= 1'b1;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_epoch_seconds = rsp_secs_ff;
   assign rsp_valid_res     = rsp_res_ff;

endmodule

FILE: tb/testbench.sv
// Testbench for broken_down_time_to_epoch_seconds: queue-fed driver, checking monitor, watchdog.
module testbench
   import bdt_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES   = 8;
   localparam int RANDOM_ITEMS   = 270;
   localparam int DRAIN_EVERY    = 90;     // random items between forced drain pauses
   localparam int HOLDOFF_AT     = 84;     // transfers taken before the long rsp hold-off
   localparam int HOLDOFF_CYCLES = 2500;   // longer than the slowest conversion
   localparam int STUCK_LIMIT    = 25000;  // cycles without any transfer before giving up
   localparam int TAIL_CYCLES    = 200;    // quiet time after the last result
   localparam int MAX_REPORTS    = 10;
   localparam int SECS_PER_HOUR  = MINS_PER_HOUR * 60;

   typedef struct {
      logic [5:0]        second;
      logic [5:0]        minute;
      logic [4:0]        hour;
      logic [4:0]        day_of_month;
      logic [3:0]        month_index;
      logic [11:0]       year_value;
      logic signed [11:0] zone_minutes;
      logic              dst_active;
      bit                drain_first;   // sender waits for all results before offering this one
   } time_request_type;

   typedef struct {
      logic signed [EPOCH_W-1:0] seconds;
      logic                      in_range;
   } epoch_result_type;

   typedef enum int {
      STALL_NONE,
      STALL_HALF,
      STALL_RARE,
      STALL_MOST
   } rx_pattern_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [5:0]                req_second = '0;
   logic [5:0]                req_minute = '0;
   logic [4:0]                req_hour = '0;
   logic [4:0]                req_day_of_month = '0;
   logic [3:0]                req_month_index = '0;
   logic [11:0]               req_year_value = '0;
   logic signed [11:0]        req_zone_minutes = '0;
   logic                      req_dst_active = 1'b0;

   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [EPOCH_W-1:0] rsp_epoch_seconds;
   logic                      rsp_valid_res;

   time_request_type pending_items[$];    // not yet taken by the block
   epoch_result_type epoch_expected[$];   // predicted results, oldest first

   logic req_accepted = 1'b0;          // request transfer at the last rising edge
   bit   hold_for_drain = 1'b0;
   int   items_accepted = 0;
   int   results_seen = 0;
   int   rejected_seen = 0;
   int   failures = 0;
   int   stuck_cycles = 0;

   broken_down_time_to_epoch_seconds DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_second        (req_second),
      .req_minute        (req_minute),
      .req_hour          (req_hour),
      .req_day_of_month  (req_day_of_month),
      .req_month_index   (req_month_index),
      .req_year_value    (req_year_value),
      .req_zone_minutes  (req_zone_minutes),
      .req_dst_active    (req_dst_active),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_epoch_seconds (rsp_epoch_seconds),
      .rsp_valid_res     (rsp_valid_res)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Leap days in years 1..y (Gregorian), y >= 0.
   function automatic longint leap_days_through(input longint y);
      return y / 4 - y / 100 + y / LEAP_CYCLE;
   endfunction

   // Expected conversion of one broken-down time.
   function automatic epoch_result_type civil_to_epoch(input time_request_type c);
      epoch_result_type r;
      longint        yr;
      longint        days;
      longint        total;
      r.seconds  = '1;
      r.in_range = 1'b0;
      if (c.second > MAX_SECOND || c.minute > MAX_MINUTE || c.hour > MAX_HOUR ||
          c.day_of_month == 0 || c.month_index > MAX_MONTH)
         return r;
      // two-digit and offset years: first +1900, then +100 if still before the epoch
      yr = c.year_value;
      if (yr < EPOCH_YEAR) yr += CENTURY_BASE;
      if (yr < EPOCH_YEAR) yr += CENTURY_STEP;
      days = (yr - EPOCH_YEAR) * DAYS_PER_YEAR +
             leap_days_through(yr - 1) - leap_days_through(EPOCH_YEAR - 1);
      for (int m = 0; m < c.month_index; m++) begin
         case (m)
            FEB_INDEX:    days += 28;
            3, 5, 8, 10:  days += 30;
            default:      days += 31;
         endcase
      end
      if (c.month_index > FEB_INDEX &&
          ((yr % 4 == 0 && yr % 100 != 0) || yr % LEAP_CYCLE == 0))
         days += 1;
      // day of month is not clipped to the month length, so it simply rolls over
      days += longint'(c.day_of_month) - 1;
      total = ((days * HOURS_PER_DAY + longint'(c.hour)) * MINS_PER_HOUR +
               longint'(c.minute)) * 60 + longint'(c.second);
      total -= 60 * longint'(c.zone_minutes);
      if (c.dst_active) total -= SECS_PER_HOUR;
      r.seconds  = total[EPOCH_W-1:0];
      r.in_range = 1'b1;
      return r;
   endfunction

   task automatic add_request(input int s, input int m, input int h, input int d,
                              input int mo, input int y, input int z, input int dst);
      time_request_type r;
      r.second       = s[5:0];
      r.minute       = m[5:0];
      r.hour         = h[4:0];
      r.day_of_month = d[4:0];
      r.month_index  = mo[3:0];
      r.year_value   = y[11:0];
      r.zone_minutes = z[11:0];
      r.dst_active   = dst[0];
      r.drain_first  = hold_for_drain;
      hold_for_drain = 1'b0;
      pending_items.push_back(r);
   endtask

   task automatic log_failure(input string what);
      failures++;
      if (failures <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
   endtask

   // Sender: bursts of transfers separated by random gaps; a presented item holds
   // until it is taken.
   always @(negedge clock) begin : driver
      int burst_left = 4;
      int gap_left = 0;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_accepted) begin
            void'(pending_items.pop_front());
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 6);
               case ($urandom_range(0, 3))
                  0:       gap_left = 0;
                  1:       gap_left = $urandom_range(1, 3);
                  2:       gap_left = $urandom_range(4, 40);
                  default: gap_left = $urandom_range(100, 400);
               endcase
            end
         end
         if (req_valid && !req_accepted) begin
            // still waiting for the block: payload and valid stay put
         end else if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_items.size() != 0 &&
                      (!pending_items[0].drain_first || epoch_expected.size() == 0)) begin
            req_second       <= pending_items[0].second;
            req_minute       <= pending_items[0].minute;
            req_hour         <= pending_items[0].hour;
            req_day_of_month <= pending_items[0].day_of_month;
            req_month_index  <= pending_items[0].month_index;
            req_year_value   <= pending_items[0].year_value;
            req_zone_minutes <= pending_items[0].zone_minutes;
            req_dst_active   <= pending_items[0].dst_active;
            req_valid        <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: stall pattern that is redrawn at random intervals, plus one long
   // hold-off so the finished item backs up and the block stalls its input.
   always @(negedge clock) begin : receiver
      rx_pattern_type pattern = STALL_NONE;
      int          pattern_left = 0;
      int          holdoff_left = 0;
      bit          holdoff_done = 1'b0;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (holdoff_left != 0) begin
         holdoff_left--;
         rsp_stall <= 1'b1;
      end else if (!holdoff_done && items_accepted >= HOLDOFF_AT) begin
         holdoff_done = 1'b1;
         holdoff_left = HOLDOFF_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         if (pattern_left == 0) begin
            pattern      = rx_pattern_type'($urandom_range(0, 3));
            pattern_left = $urandom_range(32, 256);
         end else begin
            pattern_left--;
         end
         case (pattern)
            STALL_NONE: rsp_stall <= 1'b0;
            STALL_HALF: rsp_stall <= 1'($urandom_range(0, 1));
            STALL_RARE: rsp_stall <= ($urandom_range(0, 7) == 0);
            default:    rsp_stall <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // Monitor: checks each result transfer against the oldest prediction, then
   // predicts the request taken at this edge. Also counts cycles with no transfer.
   always @(posedge clock) begin : monitor
      time_request_type seen;
      epoch_result_type want;
      if (reset) begin
         req_accepted <= 1'b0;
         stuck_cycles = 0;
      end else begin
         req_accepted <= req_valid && !req_stall;
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            stuck_cycles = 0;
         else
            stuck_cycles++;

         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (epoch_expected.size() == 0) begin
               log_failure($sformatf("result with nothing outstanding: seconds %0d valid_res %b",
                                     rsp_epoch_seconds, rsp_valid_res));
            end else begin
               want = epoch_expected.pop_front();
               if (!want.in_range) rejected_seen++;
               if (rsp_epoch_seconds !== want.seconds || rsp_valid_res !== want.in_range)
                  log_failure($sformatf(
                     "result %0d: seconds exp %0d got %0d, valid_res exp %b got %b",
                     results_seen, want.seconds, rsp_epoch_seconds,
                     want.in_range, rsp_valid_res));
            end
         end

         if (req_valid && !req_stall) begin
            seen.second       = req_second;
            seen.minute       = req_minute;
            seen.hour         = req_hour;
            seen.day_of_month = req_day_of_month;
            seen.month_index  = req_month_index;
            seen.year_value   = req_year_value;
            seen.zone_minutes = req_zone_minutes;
            seen.dst_active   = req_dst_active;
            seen.drain_first  = 1'b0;
            epoch_expected.push_back(civil_to_epoch(seen));
            items_accepted++;
         end
      end
   end

   initial begin : stimulus
      int sec;
      int mins;
      int hrs;
      int day;
      int mon;
      int yr;
      int zone;
      bit wild;

      // Directed: args are second, minute, hour, day, month, year, zone, dst.
      add_request( 0,  0,  0,  1,  0,   70,     0, 0);  // epoch origin, two-digit year
      add_request( 0,  0,  0,  1,  0, 1970,     0, 0);
      add_request( 0,  0,  0,  1,  0,    0,     0, 0);  // 0 -> 2000 after both offsets
      add_request(59, 59, 23, 31, 11,   69,     0, 0);  // 69 -> 2069
      add_request( 0,  0,  0,  1,  0,   99,     0, 0);  // 99 -> 1999
      add_request( 0,  0,  0,  1,  0,  100,     0, 0);  // 100 -> 2000
      add_request( 0,  0,  0,  1,  0, 1969,     0, 0);  // 1969 -> 3869
      add_request( 0,  0,  0,  1,  0, 1899,     0, 1);  // 1899 -> 3799
      add_request(61, 59, 23, 31, 11, 4095, -2048, 0);  // largest result
      add_request( 0,  0,  0,  1,  0, 1970,  2047, 1);  // most negative result
      add_request(62,  0,  0,  1,  0, 2000,     0, 0);  // leap second limit exceeded
      add_request(63, 63, 31,  0, 15, 4095,    -1, 1);  // every field out of range
      add_request( 0, 60,  0,  1,  0, 2000,     0, 0);
      add_request( 0,  0, 24,  1,  0, 2000,     0, 0);
      add_request( 0,  0,  0,  0,  0, 2000,     0, 0);  // day zero
      add_request( 0,  0,  0,  1, 12, 2000,     0, 0);
      add_request( 0,  0,  0, 29,  1, 2000,     0, 0);  // Feb 29 in a leap year
      add_request( 0,  0,  0, 31,  1, 2001,     0, 0);  // Feb 31 rolls into March
      add_request( 0,  0,  0,  1,  2, 2100,     0, 0);  // century, not leap
      add_request( 0,  0,  0,  1,  2, 2400,     0, 0);  // 400-year leap
      add_request( 0,  0,  0, 31,  3, 2024,     0, 0);  // April 31 rolls over
      add_request(30, 30, 12, 15,  6, 2024,  1440, 0);
      add_request(30, 30, 12, 15,  6, 2024, -1440, 1);

      // Random: mostly in-range fields and short year walks, some of everything else.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         hold_for_drain = (n % DRAIN_EVERY == 0);
         wild = ($urandom_range(0, 3) == 0);
         sec  = wild ? $urandom_range(0, 63) : $urandom_range(0, MAX_SECOND);
         mins = wild ? $urandom_range(0, 63) : $urandom_range(0, MAX_MINUTE);
         hrs  = wild ? $urandom_range(0, 31) : $urandom_range(0, MAX_HOUR);
         day  = wild ? $urandom_range(0, 31) : $urandom_range(1, 31);
         mon  = wild ? $urandom_range(0, 15) : $urandom_range(0, MAX_MONTH);
         case ($urandom_range(0, 9))
            0, 1:    yr = $urandom_range(0, 4095);
            2, 3:    yr = $urandom_range(EPOCH_YEAR, 2200);
            default: yr = $urandom_range(0, 199);
         endcase
         if ($urandom_range(0, 9) < 7)
            zone = $urandom_range(0, 2880) - 1440;
         else
            zone = $urandom_range(0, 4095);
         add_request(sec, mins, hrs, day, mon, yr, zone, $urandom_range(0, 1));
      end

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      while ((pending_items.size() != 0 || epoch_expected.size() != 0) &&
             stuck_cycles < STUCK_LIMIT)
         @(negedge clock);

      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("Timeout after %0d idle cycles: %0d items unsent, %0d results outstanding",
                  stuck_cycles, pending_items.size(), epoch_expected.size());
         $display("TEST FAILED");
         $finish;
      end else begin
         repeat (TAIL_CYCLES) @(negedge clock);
         $display("Converted %0d broken-down times (%0d rejected as out of range), %0d checked.",
                  items_accepted, rejected_seen, results_seen);
         $display("Exercised year offsets, leap/century rules, day rollover, zone/DST, stalls.");
         if (failures == 0) begin
            $display("TEST PASSED");
         end else begin
            $display("%0d mismatching results", failures);
            $display("TEST FAILED");
         end
         $finish;
      end
   end

endmodule
